FILE: rtl/core/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator package
// Sizes, item types, fit modes, register indexes and the types passed
// between the controller and the partition cells.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int PARTITIONS = 16;
    localparam int SIZE_BITS  = 16;

    // Fixed field widths of the item and register formats.
    localparam int ENTRY_INDEX_BITS = 4;
    localparam int REQ_BITS         = 16;
    localparam int COUNT_BITS       = 5;
    localparam int MODE_BITS        = 2;
    localparam int CFG_DATA_BITS    = 5;

    // Partition index width and the widths used for widened compares.
    localparam int IDX_BITS       = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CMP_BITS       = (SIZE_BITS > REQ_BITS) ? SIZE_BITS : REQ_BITS;
    localparam int CNT_CMP_BITS   = (IDX_BITS > COUNT_BITS) ? IDX_BITS : COUNT_BITS;
    localparam int ENTRY_LIM_BITS = ($clog2(PARTITIONS + 1) > ENTRY_INDEX_BITS) ?
                                    $clog2(PARTITIONS + 1) : ENTRY_INDEX_BITS;

    typedef enum logic [MODE_BITS-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    typedef enum logic {
        CFG_FIT_MODE   = 1'b0,
        CFG_PART_COUNT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_REQUEST = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic                        action;
        logic [ENTRY_INDEX_BITS-1:0] entry_index;
        logic [15:0]                 entry_size;
        logic [REQ_BITS-1:0]         request_size;
    } in_item_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_index;
        logic [15:0] size_before;
    } out_item_t;

    // Search state handed from cell to cell.
    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  pick;
        logic [SIZE_BITS-1:0] best;
    } token_t;

    // Request context broadcast to every cell during a scan.
    typedef struct packed {
        logic [REQ_BITS-1:0]   req;
        logic [MODE_BITS-1:0]  mode;
        logic [COUNT_BITS-1:0] count;
    } scan_ctl_t;

    // Size write broadcast to every cell (loads and grants).
    typedef struct packed {
        logic                 en;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] data;
    } size_wr_t;

endpackage

FILE: rtl/core/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// First, best and worst fit placement over a table of partition sizes.
// ----------------------------------------------------------------------------
// Each partition's remaining size lives in its own cell; the cells form a
// chain, and a search token moves one cell further on every clock. A load
// item writes one partition's size in the cycle it is accepted and gives no
// result. A request item's result is registered once the token has walked
// the whole chain, in the scan state, and a write-back state has decided the
// grant, written the reduced size back into the chosen cell and loaded the
// output register. The input is stalled through the walk and the write-back,
// and the next item is taken in the cycle after the result is registered at
// the earliest. If the previous result is still stalled in the output
// register, the write-back step waits until the output register is free.
// The chain length fixes the walk; partitions beyond the configured count
// are still walked but never chosen. Ties go to the lowest index because a
// later cell only replaces the token on a strictly better size. Best fit
// refuses a match whose remaining size is zero, and the unused fit mode
// grants nothing. Configuration registers are to be written through the
// cfg port only while the block is idle; the user is bound to this, and the
// block itself does not enforce it. A finished result waits in the output
// register while the next item is accepted.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  fpfa_pkg::in_item_t                 in_item,
    output logic                               out_valid,
    input  logic                               out_stall,
    output fpfa_pkg::out_item_t                out_item,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    fpfa_pkg::state_t                 state_reg;
    fpfa_pkg::state_t                 state_next;
    logic [fpfa_pkg::IDX_BITS-1:0]    cnt_reg;
    logic [fpfa_pkg::IDX_BITS-1:0]    cnt_next;
    logic [fpfa_pkg::MODE_BITS-1:0]   mode_reg;
    logic [fpfa_pkg::COUNT_BITS-1:0]  count_reg;
    logic [fpfa_pkg::REQ_BITS-1:0]    req_reg;
    logic [fpfa_pkg::REQ_BITS-1:0]    req_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    fpfa_pkg::out_item_t              out_item_reg;
    fpfa_pkg::out_item_t              out_item_next;

    fpfa_pkg::scan_ctl_t              scan;
    fpfa_pkg::size_wr_t               wr;
    fpfa_pkg::token_t                 chain [fpfa_pkg::PARTITIONS+1];
    fpfa_pkg::token_t                 last;
    logic                             in_accept;
    logic                             out_free;
    logic                             load_in_range;
    logic                             grant;
    logic [fpfa_pkg::CMP_BITS-1:0]    remain_c;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign scan.req   = req_reg;
    assign scan.mode  = mode_reg;
    assign scan.count = count_reg;

    // The chain starts from an empty token every cycle.
    assign chain[0] = '0;
    assign last     = chain[fpfa_pkg::PARTITIONS];

    genvar gi;
    generate
        for (gi = 0; gi < fpfa_pkg::PARTITIONS; gi++)
        begin : g_cell
            fpfa_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (fpfa_pkg::IDX_BITS'(gi)),
                .scan       (scan),
                .wr         (wr),
                .token_in   (chain[gi]),
                .token_out  (chain[gi+1])
            );
        end
    endgenerate

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= fpfa_pkg::FIT_FIRST;
            count_reg <= fpfa_pkg::COUNT_BITS'(16);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                fpfa_pkg::CFG_FIT_MODE:   mode_reg  <= cfg_data[fpfa_pkg::MODE_BITS-1:0];
                fpfa_pkg::CFG_PART_COUNT: count_reg <= cfg_data[fpfa_pkg::COUNT_BITS-1:0];
                default:                  mode_reg  <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpfa_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        load_in_range = fpfa_pkg::ENTRY_LIM_BITS'(in_item.entry_index)
                        < fpfa_pkg::ENTRY_LIM_BITS'(fpfa_pkg::PARTITIONS);
        case (mode_reg)
            fpfa_pkg::FIT_FIRST: grant = last.found;
            fpfa_pkg::FIT_BEST:  grant = last.found && (last.best != '0);
            fpfa_pkg::FIT_WORST: grant = last.found;
            default:             grant = 1'b0;
        endcase
        remain_c = fpfa_pkg::CMP_BITS'(last.best) - fpfa_pkg::CMP_BITS'(req_reg);

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        wr             = '0;

        unique case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_accept)
                begin
                    if (in_item.action == fpfa_pkg::ACT_LOAD)
                    begin
                        wr.en   = load_in_range;
                        wr.idx  = fpfa_pkg::IDX_BITS'(in_item.entry_index);
                        wr.data = fpfa_pkg::SIZE_BITS'(in_item.entry_size);
                    end
                    else
                    begin
                        req_next   = in_item.request_size;
                        cnt_next   = '0;
                        state_next = fpfa_pkg::ST_SCAN;
                    end
                end
            end
            fpfa_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == fpfa_pkg::IDX_BITS'(fpfa_pkg::PARTITIONS - 1))
                begin
                    state_next = fpfa_pkg::ST_WRITE;
                end
            end
            fpfa_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    wr.en          = grant;
                    wr.idx         = last.pick;
                    wr.data        = fpfa_pkg::SIZE_BITS'(remain_c);
                    out_valid_next = 1'b1;
                    if (grant)
                    begin
                        out_item_next.granted      = 1'b1;
                        out_item_next.chosen_index = 4'(last.pick);
                        out_item_next.size_before  = 16'(last.best);
                    end
                    else
                    begin
                        out_item_next = '0;
                    end
                    state_next = fpfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // No size write may land while the token is walking the chain.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpfa_pkg::ST_SCAN) |-> !wr.en)
        else $error("size write during a scan");

    // A request reaches the write-back step exactly after the chain walk.
    a_scan_length: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_item.action == fpfa_pkg::ACT_REQUEST)
        |-> ##(fpfa_pkg::PARTITIONS + 1) (state_reg == fpfa_pkg::ST_WRITE))
        else $error("scan length differs from the chain length");

    // A new result is only ever loaded from the write-back step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fpfa_pkg::ST_WRITE))
        else $error("result appeared outside write-back");

    // A refused request carries all-zero index and size.
    a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.granted)
        |-> (out_item_reg.chosen_index == '0 && out_item_reg.size_before == '0))
        else $error("refused result carries nonzero fields");

endmodule

FILE: rtl/core/fpfa_cell.sv
// ----------------------------------------------------------------------------
// Partition cell
// Holds the remaining size of one partition, updates the passing search
// token under the current fit mode, and takes size writes aimed at it.
// ----------------------------------------------------------------------------
module fpfa_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fpfa_pkg::IDX_BITS-1:0] cell_index,
    input  fpfa_pkg::scan_ctl_t           scan,
    input  fpfa_pkg::size_wr_t            wr,
    input  fpfa_pkg::token_t              token_in,
    output fpfa_pkg::token_t              token_out
);

    logic [fpfa_pkg::SIZE_BITS-1:0] size_reg;
    fpfa_pkg::token_t               token_reg;
    fpfa_pkg::token_t               token_next;
    logic [fpfa_pkg::CMP_BITS-1:0]  size_c;
    logic [fpfa_pkg::CMP_BITS-1:0]  req_c;
    logic [fpfa_pkg::CMP_BITS-1:0]  best_c;
    logic                           in_use;
    logic                           fits;
    logic                           take;

    always_comb
    begin
        size_c = fpfa_pkg::CMP_BITS'(size_reg);
        req_c  = fpfa_pkg::CMP_BITS'(scan.req);
        best_c = fpfa_pkg::CMP_BITS'(token_in.best);
        in_use = fpfa_pkg::CNT_CMP_BITS'(cell_index) < fpfa_pkg::CNT_CMP_BITS'(scan.count);
        fits   = in_use && (req_c <= size_c);
        case (scan.mode)
            fpfa_pkg::FIT_FIRST: take = fits && !token_in.found;
            fpfa_pkg::FIT_BEST:  take = fits && (!token_in.found || size_c < best_c);
            fpfa_pkg::FIT_WORST: take = fits && (size_c > best_c);
            default:             take = 1'b0;
        endcase
        if (take)
        begin
            token_next.found = 1'b1;
            token_next.pick  = cell_index;
            token_next.best  = size_reg;
        end
        else
        begin
            token_next = token_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
        end
        else if (wr.en && (wr.idx == cell_index))
        begin
            size_reg <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        token_reg <= token_next;
    end

    assign token_out = token_reg;

endmodule
